// File: src/rgbfe_pkg.sv
// Shared types and constants of the RGB fade envelope block.
package rgbfe_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned CfgIndexWidth = 8;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned ColorWidth    = 8;

  localparam logic [CfgIndexWidth-1:0] RegFadeIn   = 8'd0;
  localparam logic [CfgIndexWidth-1:0] RegHold     = 8'd1;
  localparam logic [CfgIndexWidth-1:0] RegFadeOut  = 8'd2;
  localparam logic [CfgIndexWidth-1:0] RegDark     = 8'd3;
  localparam logic [CfgIndexWidth-1:0] RegRed      = 8'd4;
  localparam logic [CfgIndexWidth-1:0] RegGreen    = 8'd5;
  localparam logic [CfgIndexWidth-1:0] RegBlue     = 8'd6;
  localparam logic [CfgIndexWidth-1:0] RegEnable   = 8'd7;

  typedef enum logic [1:0] {
    ChRed   = 2'd0,
    ChGreen = 2'd1,
    ChBlue  = 2'd2
  } channel_e;

  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StSum  = 2'd1,
    StSel  = 2'd2,
    StDiv  = 2'd3
  } state_e;

endpackage

// File: src/rgb_led_fade_envelope_top.sv
// Top level of the RGB fade envelope: configuration, phase sequencer and result register.
//
//   channel | direction | handshake                  | payload
//   cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//   tick    | in        | tick_valid_i / tick_ready_o| tick_pulse_i
//   result  | out       | res_valid_o / res_ready_i  | led_*_o, drive_valid_o, cycle_done_o
//
// An enabled tick passes from its beat through the phase sums and selection, then
// through the shared divide step for each color channel in turn, bit by bit.
// A disabled tick gives its result in the next cycle; a tick beat with the pulse
// low gives no result. Reset clears the configuration, state, result valid and step
// counter at once. A stalled result holds the block from taking the next tick beat.
module rgb_led_fade_envelope_top
  import rgbfe_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  input  logic                     tick_valid_i,
  output logic                     tick_ready_o,
  input  logic                     tick_pulse_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic [ColorWidth-1:0]    led_red_o,
  output logic [ColorWidth-1:0]    led_green_o,
  output logic [ColorWidth-1:0]    led_blue_o,
  output logic                     drive_valid_o,
  output logic                     cycle_done_o
);

  localparam int unsigned CtrWidth = COUNT_WIDTH + 2;

  logic [COUNT_WIDTH-1:0] fade_in_q, hold_q, fade_out_q, dark_q;
  logic [ColorWidth-1:0]  red_q, green_q, blue_q;
  logic                   enable_q;

  state_e                 state_q, state_d;
  logic [CtrWidth-1:0]    ctr_q, ctr_d;
  logic [CtrWidth-1:0]    b1_q, b1_d;
  logic [CtrWidth-1:0]    pair_q, pair_d;
  logic [COUNT_WIDTH-1:0] mult_q, mult_d;
  logic [COUNT_WIDTH-1:0] div_q, div_d;
  logic [COUNT_WIDTH-1:0] rem_q, rem_d;
  logic [ColorWidth-1:0]  quot_q, quot_d;
  channel_e               ch_q, ch_d;
  logic [2:0]             bit_q, bit_d;
  logic                   done_q, done_d;

  logic                   res_valid_q, res_valid_d;
  logic [ColorWidth-1:0]  led_red_q, led_red_d;
  logic [ColorWidth-1:0]  led_green_q, led_green_d;
  logic [ColorWidth-1:0]  led_blue_q, led_blue_d;
  logic                   drive_valid_q, drive_valid_d;
  logic                   cycle_done_q, cycle_done_d;

  logic                   tick_beat;
  logic [CtrWidth-1:0]    b2, total;
  logic [ColorWidth-1:0]  color;
  logic [COUNT_WIDTH-1:0] step_rem;
  logic [1:0]             step_qinc;
  logic [ColorWidth-1:0]  quot_next;

  assign cfg_ready_o   = 1'b1;
  assign tick_ready_o  = (state_q == StIdle) && (!res_valid_q || res_ready_i);
  assign tick_beat     = tick_valid_i && tick_ready_o;

  assign res_valid_o   = res_valid_q;
  assign led_red_o     = led_red_q;
  assign led_green_o   = led_green_q;
  assign led_blue_o    = led_blue_q;
  assign drive_valid_o = drive_valid_q;
  assign cycle_done_o  = cycle_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_in_q  <= '0;
      hold_q     <= '0;
      fade_out_q <= '0;
      dark_q     <= '0;
      red_q      <= '0;
      green_q    <= '0;
      blue_q     <= '0;
      enable_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegFadeIn:  fade_in_q  <= COUNT_WIDTH'(cfg_data_i);
        RegHold:    hold_q     <= COUNT_WIDTH'(cfg_data_i);
        RegFadeOut: fade_out_q <= COUNT_WIDTH'(cfg_data_i);
        RegDark:    dark_q     <= COUNT_WIDTH'(cfg_data_i);
        RegRed:     red_q      <= cfg_data_i[ColorWidth-1:0];
        RegGreen:   green_q    <= cfg_data_i[ColorWidth-1:0];
        RegBlue:    blue_q     <= cfg_data_i[ColorWidth-1:0];
        RegEnable:  enable_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ch_q)
      ChRed:   color = red_q;
      ChGreen: color = green_q;
      ChBlue:  color = blue_q;
      default: color = '0;
    endcase
  end

  rgbfe_div_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_div_step (
    .rem_i      (rem_q),
    .mult_i     (mult_q),
    .divisor_i  (div_q),
    .color_bit_i(color[bit_q]),
    .rem_o      (step_rem),
    .quot_inc_o (step_qinc)
  );

  // The quotient can grow by two in one step, so the increment is added to the shifted quotient.
  assign quot_next = {quot_q[ColorWidth-2:0], 1'b0} + ColorWidth'(step_qinc);
  assign b2        = b1_q + CtrWidth'(fade_out_q);
  assign total     = b1_q + pair_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ctr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_q          <= b1_d;
    pair_q        <= pair_d;
    mult_q        <= mult_d;
    div_q         <= div_d;
    rem_q         <= rem_d;
    quot_q        <= quot_d;
    ch_q          <= ch_d;
    bit_q         <= bit_d;
    done_q        <= done_d;
    led_red_q     <= led_red_d;
    led_green_q   <= led_green_d;
    led_blue_q    <= led_blue_d;
    drive_valid_q <= drive_valid_d;
    cycle_done_q  <= cycle_done_d;
  end

  always_comb begin
    state_d       = state_q;
    ctr_d         = ctr_q;
    b1_d          = b1_q;
    pair_d        = pair_q;
    mult_d        = mult_q;
    div_d         = div_q;
    rem_d         = rem_q;
    quot_d        = quot_q;
    ch_d          = ch_q;
    bit_d         = bit_q;
    done_d        = done_q;
    res_valid_d   = res_valid_q && !res_ready_i;
    led_red_d     = led_red_q;
    led_green_d   = led_green_q;
    led_blue_d    = led_blue_q;
    drive_valid_d = drive_valid_q;
    cycle_done_d  = cycle_done_q;

    case (state_q)
      StIdle: begin
        if (tick_beat && tick_pulse_i) begin
          if (enable_q) begin
            state_d = StSum;
          end else begin
            res_valid_d   = 1'b1;
            led_red_d     = '0;
            led_green_d   = '0;
            led_blue_d    = '0;
            drive_valid_d = 1'b0;
            cycle_done_d  = 1'b0;
          end
        end
      end
      StSum: begin
        b1_d    = CtrWidth'(fade_in_q) + CtrWidth'(hold_q);
        pair_d  = CtrWidth'(fade_out_q) + CtrWidth'(dark_q);
        state_d = StSel;
      end
      StSel: begin
        // Full color runs the divider with equal factor and divisor; black with factor zero.
        if (ctr_q < CtrWidth'(fade_in_q)) begin
          mult_d = ctr_q[COUNT_WIDTH-1:0];
          div_d  = fade_in_q;
        end else if (ctr_q < b1_q) begin
          mult_d = COUNT_WIDTH'(1);
          div_d  = COUNT_WIDTH'(1);
        end else if (ctr_q < b2) begin
          mult_d = COUNT_WIDTH'(b2 - ctr_q);
          div_d  = fade_out_q;
        end else begin
          mult_d = '0;
          div_d  = COUNT_WIDTH'(1);
        end
        if (ctr_q >= total) begin
          ctr_d  = '0;
          done_d = 1'b1;
        end else begin
          ctr_d  = ctr_q + CtrWidth'(1);
          done_d = 1'b0;
        end
        rem_d   = '0;
        quot_d  = '0;
        ch_d    = ChRed;
        bit_d   = 3'd7;
        state_d = StDiv;
      end
      StDiv: begin
        rem_d  = step_rem;
        quot_d = quot_next;
        bit_d  = bit_q - 3'd1;
        if (bit_q == 3'd0) begin
          rem_d = '0;
          case (ch_q)
            ChRed: begin
              led_red_d = quot_next;
              ch_d      = ChGreen;
            end
            ChGreen: begin
              led_green_d = quot_next;
              ch_d        = ChBlue;
            end
            default: begin
              led_blue_d    = quot_next;
              drive_valid_d = 1'b1;
              cycle_done_d  = done_q;
              res_valid_d   = 1'b1;
              state_d       = StIdle;
            end
          endcase
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// File: src/rgbfe_div_step.sv
// One step of the bit-serial scale-and-divide unit: r = 2r + bit*m, reduced modulo d.
module rgbfe_div_step
  import rgbfe_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic [COUNT_WIDTH-1:0] rem_i,
  input  logic [COUNT_WIDTH-1:0] mult_i,
  input  logic [COUNT_WIDTH-1:0] divisor_i,
  input  logic                   color_bit_i,
  output logic [COUNT_WIDTH-1:0] rem_o,
  output logic [1:0]             quot_inc_o
);

  logic [COUNT_WIDTH+1:0] sum;
  logic [COUNT_WIDTH+1:0] one_div;
  logic [COUNT_WIDTH+1:0] two_div;
  logic [COUNT_WIDTH+1:0] diff_one;
  logic [COUNT_WIDTH+1:0] diff_two;

  // The remainder stays below the divisor and the factor never exceeds it, so the
  // sum stays below three divisors and at most two subtractions bring it back.
  always_comb begin
    sum      = {1'b0, rem_i, 1'b0}
             + (color_bit_i ? {2'b00, mult_i} : {(COUNT_WIDTH+2){1'b0}});
    one_div  = {2'b00, divisor_i};
    two_div  = {1'b0, divisor_i, 1'b0};
    diff_one = sum - one_div;
    diff_two = sum - two_div;
    if (sum >= two_div) begin
      quot_inc_o = 2'd2;
      rem_o      = diff_two[COUNT_WIDTH-1:0];
    end else if (sum >= one_div) begin
      quot_inc_o = 2'd1;
      rem_o      = diff_one[COUNT_WIDTH-1:0];
    end else begin
      quot_inc_o = 2'd0;
      rem_o      = sum[COUNT_WIDTH-1:0];
    end
  end

endmodule

// File: src/rgbfe_checker.sv
// Port-level assertions for the RGB fade envelope, bound to its top level.
module rgbfe_checker
  import rgbfe_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  tick_ready_o,
  input logic                  res_valid_o,
  input logic                  res_ready_i,
  input logic [ColorWidth-1:0] led_red_o,
  input logic [ColorWidth-1:0] led_green_o,
  input logic [ColorWidth-1:0] led_blue_o,
  input logic                  drive_valid_o,
  input logic                  cycle_done_o
);

  // A stalled result beat keeps its valid.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o)
    else $error("result valid dropped while stalled");

  // No new tick is taken while the previous result is still stalled.
  a_no_tick_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |-> !tick_ready_o)
    else $error("tick taken while result stalled");

  // A result that was not driven is black and never ends a cycle.
  a_undriven_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !drive_valid_o |->
      led_red_o == '0 && led_green_o == '0 && led_blue_o == '0 && !cycle_done_o)
    else $error("undriven result carries color or cycle end");

  a_done_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && cycle_done_o |-> drive_valid_o)
    else $error("cycle end flagged on undriven result");

endmodule

bind rgb_led_fade_envelope_top rgbfe_checker u_rgbfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tick_ready_o (tick_ready_o),
  .res_valid_o  (res_valid_o),
  .res_ready_i  (res_ready_i),
  .led_red_o    (led_red_o),
  .led_green_o  (led_green_o),
  .led_blue_o   (led_blue_o),
  .drive_valid_o(drive_valid_o),
  .cycle_done_o (cycle_done_o)
);

// File: tb/tb_rgb_led_fade_envelope_top.sv
// Self-checking testbench for the RGB fade envelope block with a scoreboard class.
module tb_rgb_led_fade_envelope_top;
  import rgbfe_pkg::*;

  localparam int unsigned SettleCycles = 40;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned MaxReports   = 100;

  typedef struct packed {
    bit [ColorWidth-1:0] red;
    bit [ColorWidth-1:0] green;
    bit [ColorWidth-1:0] blue;
    bit                  driven;
    bit                  wrapped;
  } led_result_t;

  class fade_envelope_scoreboard;
    bit [CountWidthDef-1:0] fade_in_len, hold_len, fade_out_len, dark_len;
    bit [ColorWidth-1:0]    red_level, green_level, blue_level;
    bit                     enabled;
    bit [CountWidthDef+1:0] step_count;
    led_result_t            pending_levels[$];
    int unsigned            errors, results_checked, wraps, disabled_results;

    function void write_register(bit [CfgIndexWidth-1:0] idx, bit [CfgDataWidth-1:0] data);
      case (idx)
        RegFadeIn:  fade_in_len  = data;
        RegHold:    hold_len     = data;
        RegFadeOut: fade_out_len = data;
        RegDark:    dark_len     = data;
        RegRed:     red_level    = data[ColorWidth-1:0];
        RegGreen:   green_level  = data[ColorWidth-1:0];
        RegBlue:    blue_level   = data[ColorWidth-1:0];
        RegEnable:  enabled      = data[0];
        default: ;
      endcase
    endfunction

    // Level of one channel at a given step of the envelope.
    function bit [ColorWidth-1:0] level_for(bit [ColorWidth-1:0] full,
                                           bit [CountWidthDef+1:0] step);
      bit [31:0] fi, ho, fo, s, c;
      fi = fade_in_len;
      ho = hold_len;
      fo = fade_out_len;
      s  = step;
      c  = full;
      if (s < fi) return 8'((s * c) / fi);
      if (s < fi + ho) return full;
      if (s < fi + ho + fo) return 8'((c * (fo - (s - fi - ho))) / fo);
      return '0;
    endfunction

    function void note_tick(bit pulse);
      led_result_t want;
      bit [31:0]   total, next_step;
      if (!pulse) return;
      want = '0;
      if (enabled) begin
        total = 32'(fade_in_len) + 32'(hold_len) + 32'(fade_out_len) + 32'(dark_len);
        want.red    = level_for(red_level, step_count);
        want.green  = level_for(green_level, step_count);
        want.blue   = level_for(blue_level, step_count);
        want.driven = 1'b1;
        next_step   = 32'(step_count) + 1;
        // Also covers a counter left beyond a freshly shortened envelope.
        if (next_step > total) begin
          want.wrapped = 1'b1;
          next_step    = 0;
        end
        step_count = next_step[CountWidthDef+1:0];
      end
      pending_levels.push_back(want);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      if (errors < MaxReports)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(led_result_t got);
      led_result_t want;
      if (pending_levels.size() == 0) begin
        if (errors < MaxReports)
          $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_levels.pop_front();
      results_checked++;
      if (want.wrapped) wraps++;
      if (!want.driven) disabled_results++;
      if (got.red != want.red) report("led_red", want.red, got.red);
      if (got.green != want.green) report("led_green", want.green, got.green);
      if (got.blue != want.blue) report("led_blue", want.blue, got.blue);
      if (got.driven != want.driven) report("drive_valid", want.driven, got.driven);
      if (got.wrapped != want.wrapped) report("cycle_done", want.wrapped, got.wrapped);
    endfunction

    function int unsigned outstanding();
      return pending_levels.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni       = 1'b0;
  logic                     cfg_valid_i  = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i  = '0;
  logic [CfgDataWidth-1:0]  cfg_data_i   = '0;
  logic                     tick_valid_i = 1'b0;
  logic                     tick_ready_o;
  logic                     tick_pulse_i = 1'b0;
  logic                     res_valid_o;
  logic                     res_ready_i  = 1'b0;
  logic [ColorWidth-1:0]    led_red_o;
  logic [ColorWidth-1:0]    led_green_o;
  logic [ColorWidth-1:0]    led_blue_o;
  logic                     drive_valid_o;
  logic                     cycle_done_o;

  fade_envelope_scoreboard board;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_left  = 0;
  int unsigned cycle_count    = 0;
  int unsigned ticks_sent     = 0;
  int unsigned blank_ticks    = 0;
  int unsigned reg_writes     = 0;

  rgb_led_fade_envelope_top dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .tick_valid_i,
    .tick_ready_o,
    .tick_pulse_i,
    .res_valid_o,
    .res_ready_i,
    .led_red_o,
    .led_green_o,
    .led_blue_o,
    .drive_valid_o,
    .cycle_done_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check each accepted beat, then pick the next ready level.
  initial begin
    led_result_t seen;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_valid_o && res_ready_i) begin
        seen.red     = led_red_o;
        seen.green   = led_green_o;
        seen.blue    = led_blue_o;
        seen.driven  = drive_valid_o;
        seen.wrapped = cycle_done_o;
        board.check_result(seen);
      end
      if (hold_off_left > 0) begin
        res_ready_i <= 1'b0;
        hold_off_left--;
      end else begin
        res_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Leaves cfg_valid_i high so back-to-back writes stay valid; close_config lowers it.
  task automatic write_reg(input bit [CfgIndexWidth-1:0] idx, input bit [CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_register(idx, data);
    reg_writes++;
  endtask

  task automatic close_config();
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_tick(input bit pulse);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      tick_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    tick_valid_i <= 1'b1;
    tick_pulse_i <= pulse;
    do @(posedge clk_i); while (!tick_ready_o);
    board.note_tick(pulse);
    if (pulse) ticks_sent++;
    else blank_ticks++;
  endtask

  task automatic wait_results();
    tick_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.outstanding() != 0);
  endtask

  // A beat with the pulse low gives no result, so allow for it to finish too.
  task automatic settle();
    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic bit [CfgDataWidth-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 14) return '1;
    if (r < 20) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(1, 6));
  endfunction

  function automatic bit [CfgDataWidth-1:0] pick_color();
    int unsigned r;
    bit [ColorWidth-1:0] level;
    r = $urandom_range(0, 99);
    if (r < 12) level = '0;
    else if (r < 24) level = '1;
    else level = 8'($urandom_range(0, 255));
    return {8'($urandom_range(0, 255)), level};
  endfunction

  task automatic randomize_settings(input bit write_all);
    if (write_all || $urandom_range(0, 99) < 60) write_reg(RegFadeIn, pick_length());
    if (write_all || $urandom_range(0, 99) < 60) write_reg(RegHold, pick_length());
    if (write_all || $urandom_range(0, 99) < 60) write_reg(RegFadeOut, pick_length());
    if (write_all || $urandom_range(0, 99) < 60) write_reg(RegDark, pick_length());
    if (write_all || $urandom_range(0, 99) < 60) write_reg(RegRed, pick_color());
    if (write_all || $urandom_range(0, 99) < 60) write_reg(RegGreen, pick_color());
    if (write_all || $urandom_range(0, 99) < 60) write_reg(RegBlue, pick_color());
    if ($urandom_range(0, 99) < 25)
      write_reg(8'($urandom_range(8, 255)), 16'($urandom));
    if (write_all || $urandom_range(0, 99) < 60)
      write_reg(RegEnable, {15'($urandom_range(0, 32767)), 1'($urandom_range(0, 99) < 85)});
    close_config();
  endtask

  initial begin
    int unsigned items;
    board = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset everything is zero and the block is disabled.
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();

    // All lengths zero: every tick is black and wraps.
    write_reg(RegEnable, 16'h0001);
    close_config();
    send_tick(1'b1);
    send_tick(1'b1);
    settle();

    // One full short envelope plus a step into the next.
    write_reg(RegFadeIn, 16'd3);
    write_reg(RegHold, 16'd2);
    write_reg(RegFadeOut, 16'd3);
    write_reg(RegDark, 16'd2);
    write_reg(RegRed, 16'hFFFF);
    write_reg(RegGreen, 16'hFF00);
    write_reg(RegBlue, 16'h00AA);
    close_config();
    for (int i = 0; i < 12; i++) begin
      if (i == 5) send_tick(1'b0);
      send_tick(1'b1);
    end
    settle();

    // Longest fade out, then shrink the envelope below the current step.
    write_reg(RegFadeIn, 16'd0);
    write_reg(RegHold, 16'd0);
    write_reg(RegFadeOut, 16'hFFFF);
    write_reg(RegDark, 16'hFFFF);
    write_reg(RegGreen, 16'h0001);
    write_reg(RegBlue, 16'h0080);
    close_config();
    repeat (3) send_tick(1'b1);
    settle();
    write_reg(RegFadeOut, 16'd0);
    write_reg(RegDark, 16'd1);
    close_config();
    repeat (2) send_tick(1'b1);
    settle();

    // Disable with the upper data bits set, poke unmapped indexes, then re-enable.
    write_reg(RegEnable, 16'hFFFE);
    close_config();
    send_tick(1'b1);
    settle();
    write_reg(8'hFF, 16'hFFFF);
    write_reg(8'h80, 16'h0000);
    write_reg(RegEnable, 16'h0001);
    close_config();
    send_tick(1'b1);

    for (int p = 0; p < 16; p++) begin
      settle();
      randomize_settings(p == 0);
      case (p / 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      // Long receiver hold-off while the sender keeps offering beats.
      if (p == 1) hold_off_left = 400;
      items = $urandom_range(50, 70);
      for (int i = 0; i < items; i++) begin
        if ($urandom_range(0, 99) < 8) send_tick(1'b0);
        send_tick(1'b1);
        if (p == 2 && i == items / 2) wait_results();
      end
    end
    settle();

    $display("Run covered %0d ticks and %0d pulse-free beats over %0d register writes.",
             ticks_sent, blank_ticks, reg_writes);
    $display("Checked %0d results, %0d envelope wraps and %0d while disabled.",
             board.results_checked, board.wraps, board.disabled_results);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
